>>> sv/assert_macros.svh
// Assertion macros used by the back-end module of the admission block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/tcpra_pkg.sv
// Types, widths and codes shared by the two-class admission block.
`timescale 1ns / 1ps

package tcpra_pkg;

    // Sizes
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = 5;
    localparam int UNIT_W      = 9;
    localparam int TAG_W       = 8;
    localparam int LIM_W       = 5;
    localparam int KIND_W      = 2;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    // Command queue between front and back
    localparam int FQ_DEPTH    = 2;
    localparam int FQ_PTR_W    = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W    = $clog2(FQ_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_UNITS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 1'd1;

    // Reset values
    localparam logic [UNIT_W-1:0] TOTAL_UNITS_RST  = 9'd256;
    localparam logic [LIM_W-1:0]  BUFFER_LIMIT_RST = 5'd16;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DROP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd3;

    // Commands and classes
    localparam logic CMD_ARRIVE   = 1'b0;
    localparam logic CMD_COMPLETE = 1'b1;
    localparam logic CLASS_HIGH   = 1'b0;
    localparam logic CLASS_LOW    = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              cls;
        logic [UNIT_W-1:0] units;
    } t_job;

    typedef struct packed {
        logic cmd;
        t_job job;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic              cls;
        logic [UNIT_W-1:0] units;
        logic [UNIT_W-1:0] free_units;
        logic [CNT_W-1:0]  waiting;
    } t_res;

    // Back end to job store
    typedef struct packed {
        logic push;
        logic pop;
        t_job job;
    } t_st_ctl;

    // Job store to back end
    typedef struct packed {
        logic [CNT_W-1:0] hi_cnt;
        logic [CNT_W-1:0] lo_cnt;
        t_job             head;
    } t_st_stat;

endpackage

>>> sv/tcpra_front.sv
// Front end: accepts input transactions, decodes them and queues commands.
`timescale 1ns / 1ps

module tcpra_front
    import tcpra_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                 i_s_axis_tuser,
    output logic                 o_cmd_valid,
    output t_cmd                 o_cmd,
    input  logic                 i_cmd_pop
);

    t_cmd                r_q [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wr, n_wr;
    logic [FQ_PTR_W-1:0] r_rd, n_rd;
    logic [FQ_CNT_W-1:0] r_cnt, n_cnt;
    logic                push;
    t_cmd                dec;

    // Decode: class, tag and units from tdata, command from tuser
    always_comb begin
        dec.cmd       = i_s_axis_tuser;
        dec.job.cls   = i_s_axis_tdata[0];
        dec.job.tag   = i_s_axis_tdata[TAG_W:1];
        dec.job.units = i_s_axis_tdata[TAG_W+UNIT_W:TAG_W+1];
    end

    assign o_s_axis_tready = (r_cnt != FQ_CNT_W'(FQ_DEPTH));
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cmd_valid     = (r_cnt != '0);
    assign o_cmd           = r_q[r_rd];

    // Pointer and fill update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rd = (r_rd == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !i_cmd_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_cmd_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Command storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= dec;
        end
    end

endmodule

>>> sv/tcpra_store.sv
// Job store: one ring per class; the high ring always drains ahead of the low one.
`timescale 1ns / 1ps

module tcpra_store
    import tcpra_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_st_ctl  i_ctl,
    output t_st_stat o_stat
);

    t_job             r_hi [QUEUE_DEPTH];
    t_job             r_lo [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_hi_wr, r_hi_rd, r_lo_wr, r_lo_rd;
    logic [CNT_W-1:0] r_hi_cnt, r_lo_cnt;
    logic             hi_any;
    logic             push_hi, push_lo, pop_hi, pop_lo;

    assign hi_any  = (r_hi_cnt != '0);
    assign push_hi = i_ctl.push && (i_ctl.job.cls == CLASS_HIGH);
    assign push_lo = i_ctl.push && (i_ctl.job.cls == CLASS_LOW);
    assign pop_hi  = i_ctl.pop && hi_any;
    assign pop_lo  = i_ctl.pop && !hi_any;

    assign o_stat.hi_cnt = r_hi_cnt;
    assign o_stat.lo_cnt = r_lo_cnt;
    assign o_stat.head   = hi_any ? r_hi[r_hi_rd] : r_lo[r_lo_rd];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Ring pointers and occupancy; push and pop never coincide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_wr  <= '0;
            r_hi_rd  <= '0;
            r_lo_wr  <= '0;
            r_lo_rd  <= '0;
            r_hi_cnt <= '0;
            r_lo_cnt <= '0;
        end else begin
            if (push_hi) begin
                r_hi_wr  <= ptr_inc(r_hi_wr);
                r_hi_cnt <= r_hi_cnt + 1'b1;
            end else if (pop_hi) begin
                r_hi_rd  <= ptr_inc(r_hi_rd);
                r_hi_cnt <= r_hi_cnt - 1'b1;
            end
            if (push_lo) begin
                r_lo_wr  <= ptr_inc(r_lo_wr);
                r_lo_cnt <= r_lo_cnt + 1'b1;
            end else if (pop_lo) begin
                r_lo_rd  <= ptr_inc(r_lo_rd);
                r_lo_cnt <= r_lo_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push_hi) begin
            r_hi[r_hi_wr] <= i_ctl.job;
        end
        if (push_lo) begin
            r_lo[r_lo_wr] <= i_ctl.job;
        end
    end

endmodule

>>> sv/tcpra_back.sv
// Back end: executes commands, dispatches from the head and drives results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcpra_back
    import tcpra_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_pop,
    output t_st_ctl              o_ctl,
    input  t_st_stat             i_stat,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_res                 o_res,
    output logic                 o_res_last
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DISP = 1'b1;

    logic              r_state, n_state;
    logic [UNIT_W-1:0] r_total, n_total;
    logic [LIM_W-1:0]  r_limit, n_limit;
    logic [UNIT_W-1:0] r_free, n_free;
    logic [CNT_W-1:0]  r_count, n_count;
    t_res              r_pend, n_pend;
    t_res              r_out, n_out;
    logic              r_out_last, n_out_last;
    logic              r_out_valid, n_out_valid;

    logic              out_free;
    logic              full;
    logic              fits;
    logic [UNIT_W:0]   rel_sum;
    logic [UNIT_W-1:0] rel_free;
    logic [UNIT_W-1:0] disp_free;

    assign out_free  = !r_out_valid || i_res_ready;
    assign full      = (r_count >= r_limit) || (r_count >= CNT_W'(QUEUE_DEPTH));
    assign fits      = (r_count != '0) && (i_stat.head.units <= r_free);
    assign rel_sum   = {1'b0, r_free} + {1'b0, i_cmd.job.units};
    assign rel_free  = (rel_sum > {1'b0, r_total}) ? r_total : rel_sum[UNIT_W-1:0];
    assign disp_free = r_free - i_stat.head.units;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_res_last  = r_out_last;

    // Sequencer: one command result, then one dispatch per cycle unless stalled;
    // a result is held in r_pend until the next step tells whether it is last
    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_limit     = r_limit;
        n_free      = r_free;
        n_count     = r_count;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_res_ready;
        o_cmd_pop   = 1'b0;
        o_ctl       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop    = 1'b1;
                    n_state      = S_DISP;
                    n_pend.tag   = i_cmd.job.tag;
                    n_pend.cls   = i_cmd.job.cls;
                    n_pend.units = i_cmd.job.units;
                    if (i_cmd.cmd == CMD_COMPLETE) begin
                        n_free            = rel_free;
                        n_pend.kind       = KIND_RELEASE;
                        n_pend.free_units = rel_free;
                        n_pend.waiting    = r_count;
                    end else if (full) begin
                        n_pend.kind       = KIND_DROP;
                        n_pend.free_units = r_free;
                        n_pend.waiting    = r_count;
                    end else begin
                        o_ctl.push        = 1'b1;
                        o_ctl.job         = i_cmd.job;
                        n_count           = r_count + 1'b1;
                        n_pend.kind       = KIND_ACCEPT;
                        n_pend.free_units = r_free;
                        n_pend.waiting    = r_count + 1'b1;
                    end
                end
            end
            S_DISP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    if (fits) begin
                        n_out_last        = 1'b0;
                        o_ctl.pop         = 1'b1;
                        n_free            = disp_free;
                        n_count           = r_count - 1'b1;
                        n_pend.kind       = KIND_DISPATCH;
                        n_pend.tag        = i_stat.head.tag;
                        n_pend.cls        = i_stat.head.cls;
                        n_pend.units      = i_stat.head.units;
                        n_pend.free_units = disp_free;
                        n_pend.waiting    = r_count - 1'b1;
                    end else begin
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Register writes
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOTAL_UNITS:  n_total = i_cfg_wdata[UNIT_W-1:0];
                CFG_BUFFER_LIMIT: n_limit = i_cfg_wdata[LIM_W-1:0];
                default:          n_total = r_total;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= TOTAL_UNITS_RST;
            r_limit     <= BUFFER_LIMIT_RST;
            r_free      <= TOTAL_UNITS_RST;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_limit     <= n_limit;
            r_free      <= n_free;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    // Checks
    `ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `ASSERT_ALWAYS(a_count_match, {1'b0, r_count} == ({1'b0, i_stat.hi_cnt} + {1'b0, i_stat.lo_cnt}), "count differs from store")
    `ASSERT_ALWAYS(a_pop_fits, !o_ctl.pop || (i_stat.head.units <= r_free), "dispatch beyond free pool")
    `ASSERT_NEXT(a_push_counts, o_ctl.push, r_count == $past(r_count) + 1'b1, "push did not count")

endmodule

>>> sv/two_class_priority_resource_admit.sv
// Top level of the two-class priority admission block with a shared unit pool.
// Each input transaction (arrival or completion) yields one accepted, dropped or
// released result, followed by one dispatched result for every head job that
// fits the free pool; tlast marks the final result of the input. An input
// dispatches 0 to 16 jobs; the back-end sequencer emits one result per cycle,
// unless the receiver stalls it, through a single output register, and a
// closing step that finds no fitting head ends the run. A two-entry command
// queue lets the input side keep accepting while results are drained. High-class
// jobs wait in their own ring and always leave ahead of low-class jobs; a head
// that does not fit blocks everything behind it. No clearing pass after reset.
`timescale 1ns / 1ps

module two_class_priority_resource_admit
    import tcpra_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // job_class, job_tag, job_units
    input  logic                 i_s_axis_tuser,  // cmd
    // Result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // out_tag, out_class, out_units,
                                                  // free_units, waiting
    output logic [KIND_W-1:0]    o_m_axis_tuser,  // kind
    output logic                 o_m_axis_tlast
);

    logic     cmd_valid;
    t_cmd     cmd;
    logic     cmd_pop;
    t_st_ctl  st_ctl;
    t_st_stat st_stat;
    t_res     res;

    tcpra_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    tcpra_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (st_ctl),
        .o_stat  (st_stat)
    );

    tcpra_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_ctl       (st_ctl),
        .i_stat      (st_stat),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res),
        .o_res_last  (o_m_axis_tlast)
    );

    // Result packing, lowest field first
    assign o_m_axis_tdata = {res.waiting, res.free_units, res.units, res.cls, res.tag};
    assign o_m_axis_tuser = res.kind;

endmodule

>>> dv/tb_two_class_priority_resource_admit.sv
// Self-checking testbench for the two-class priority admission block.
`timescale 1ns / 1ps

module tb_two_class_priority_resource_admit;
    import tcpra_pkg::*;

    // One expected or observed result transaction
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic              cls;
        logic [UNIT_W-1:0] units;
        logic [UNIT_W-1:0] free_units;
        logic [CNT_W-1:0]  waiting;
        logic              last;
    } t_admit_result;

    // Tracks the admission queue and free pool, and checks results in order
    class admit_scoreboard;
        t_job          job_line[$];
        int unsigned   pool_free;
        int unsigned   pool_size;
        int unsigned   job_cap;
        t_admit_result pending_results[$];
        int unsigned   errors;

        function new();
            pool_size = TOTAL_UNITS_RST;
            job_cap   = BUFFER_LIMIT_RST;
            pool_free = pool_size;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_TOTAL_UNITS) begin
                pool_size = val;
            end else if (idx == CFG_BUFFER_LIMIT) begin
                job_cap = val[LIM_W-1:0];
            end
        endfunction

        function void queue_result(logic [KIND_W-1:0] kind, t_job job);
            t_admit_result r;
            r.kind       = kind;
            r.tag        = job.tag;
            r.cls        = job.cls;
            r.units      = job.units;
            r.free_units = pool_free[UNIT_W-1:0];
            r.waiting    = CNT_W'(job_line.size());
            r.last       = 1'b0;
            pending_results.insert(pending_results.size(), r);
        endfunction

        // Admit, drop or release, then dispatch heads while they fit the pool
        function void note_input(logic cmd, t_job job);
            int unsigned sum;
            int          pos;
            t_job        head;
            if (cmd == CMD_COMPLETE) begin
                sum = pool_free + job.units;
                pool_free = (sum > pool_size) ? pool_size : sum;
                queue_result(KIND_RELEASE, job);
            end else if (job_line.size() >= job_cap || job_line.size() >= QUEUE_DEPTH) begin
                queue_result(KIND_DROP, job);
            end else begin
                pos = job_line.size();
                // high class goes ahead of the first low-class job
                if (job.cls == CLASS_HIGH) begin
                    for (int i = job_line.size() - 1; i >= 0; i--) begin
                        if (job_line[i].cls == CLASS_LOW) pos = i;
                    end
                end
                job_line.insert(pos, job);
                queue_result(KIND_ACCEPT, job);
            end
            while (job_line.size() > 0 && job_line[0].units <= pool_free) begin
                head = job_line.pop_front();
                pool_free -= head.units;
                queue_result(KIND_DISPATCH, head);
            end
            pending_results[pending_results.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        task check_result(t_admit_result got);
            t_admit_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing pending: kind %0d tag %0d",
                                 got.kind, got.tag));
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind)
                    report($sformatf("kind %0d, want %0d", got.kind, want.kind));
                if (got.tag != want.tag)
                    report($sformatf("tag %0d, want %0d", got.tag, want.tag));
                if (got.cls != want.cls)
                    report($sformatf("class %0d, want %0d", got.cls, want.cls));
                if (got.units != want.units)
                    report($sformatf("units %0d, want %0d", got.units, want.units));
                if (got.free_units != want.free_units)
                    report($sformatf("free %0d, want %0d", got.free_units,
                                     want.free_units));
                if (got.waiting != want.waiting)
                    report($sformatf("waiting %0d, want %0d", got.waiting,
                                     want.waiting));
                if (got.last != want.last)
                    report($sformatf("last %0d, want %0d", got.last, want.last));
            end
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx     = CFG_TOTAL_UNITS;
    logic [CFG_W-1:0]     cfg_wdata   = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = CMD_ARRIVE;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;

    admit_scoreboard sb = new();
    bit              quiet    = 1'b0;  // no idle cycles on either side
    bit              hold_req = 1'b0;  // ask the receiver for one long stall

    two_class_priority_resource_admit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // job_class, job_tag, job_units
        .i_s_axis_tuser  (s_tuser),   // cmd
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // out_tag, out_class, out_units, free_units, waiting
        .o_m_axis_tuser  (m_tuser),   // kind
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offer one job transaction and wait until it is taken
    task send_job(logic cmd, logic cls, logic [TAG_W-1:0] tag, logic [UNIT_W-1:0] units);
        int   gap;
        t_job job;
        job.tag   = tag;
        job.cls   = cls;
        job.units = units;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - UNIT_W - TAG_W - 1){1'b0}}, units, tag, cls};
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_input(cmd, job);
    endtask

    // Stop offering and wait for every pending result
    task settle();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task cfg_write(int unsigned total, int unsigned limit);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_TOTAL_UNITS;
        cfg_wdata <= CFG_W'(total);
        @(posedge i_clk);
        sb.set_reg(CFG_TOTAL_UNITS, CFG_W'(total));
        cfg_idx   <= CFG_BUFFER_LIMIT;
        cfg_wdata <= CFG_W'(limit);
        @(posedge i_clk);
        sb.set_reg(CFG_BUFFER_LIMIT, CFG_W'(limit));
        cfg_we <= 1'b0;
    endtask

    // Empty the queue: full pool size, then full releases until all dispatched
    task flush_queue();
        while (sb.job_line.size() > 0) begin
            if (sb.pool_size != TOTAL_UNITS_RST) begin
                settle();
                cfg_write(TOTAL_UNITS_RST, sb.job_cap);
            end
            send_job(CMD_COMPLETE, CLASS_HIGH, TAG_W'($urandom_range(0, 255)), 9'd256);
            settle();
        end
    endtask

    // Random arrival or completion, steered toward unblocking a stuck head
    task send_random();
        int               r;
        int               e;
        logic [UNIT_W-1:0] units;
        bit               stuck;
        r = $urandom_range(0, 99);
        stuck = sb.job_line.size() > 0 && sb.job_line[0].units > sb.pool_free;
        if (stuck && r < 35) begin
            send_job(CMD_COMPLETE, 1'($urandom_range(0, 1)), TAG_W'($urandom_range(0, 255)),
                     UNIT_W'($urandom_range(0, sb.pool_size)));
        end else if (r < 62) begin
            e = $urandom_range(0, 19);
            if (e == 0)      units = '0;
            else if (e == 1) units = UNIT_W'(sb.pool_size);
            else if (e == 2) units = 9'd256;
            else             units = UNIT_W'($urandom_range(0, sb.pool_size));
            send_job(CMD_ARRIVE, 1'($urandom_range(0, 1)), TAG_W'($urandom_range(0, 255)),
                     units);
        end else begin
            send_job(CMD_COMPLETE, 1'($urandom_range(0, 1)), TAG_W'($urandom_range(0, 255)),
                     UNIT_W'($urandom_range(0, 256)));
        end
    endtask

    // Result side: random stalls, one long hold on request
    initial begin
        int            stall;
        t_admit_result got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall = 200;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            got.kind       = m_tuser;
            got.tag        = m_tdata[7:0];
            got.cls        = m_tdata[8];
            got.units      = m_tdata[17:9];
            got.free_units = m_tdata[26:18];
            got.waiting    = m_tdata[31:27];
            got.last       = m_tlast;
            sb.check_result(got);
        end
    end

    // Stimulus
    initial begin
        int unsigned totals[6];
        int unsigned limits[6];
        totals = '{256, 1, 0, 0, 16, 256};
        limits = '{16, 1, 16, 4, 0, 2};
        totals[2] = $urandom_range(2, 255);
        totals[3] = $urandom_range(2, 255);
        limits[4] = $urandom_range(1, 16);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero-unit dispatch, full pool, priority insertion, saturation
        send_job(CMD_ARRIVE,   CLASS_HIGH, 8'h00, 9'd0);
        send_job(CMD_ARRIVE,   CLASS_LOW,  8'hFF, 9'd256);
        send_job(CMD_ARRIVE,   CLASS_HIGH, 8'h01, 9'd1);
        send_job(CMD_ARRIVE,   CLASS_LOW,  8'h02, 9'd5);
        send_job(CMD_ARRIVE,   CLASS_HIGH, 8'h03, 9'd2);
        send_job(CMD_COMPLETE, CLASS_HIGH, 8'h10, 9'd256);
        send_job(CMD_COMPLETE, CLASS_LOW,  8'hAA, 9'd100);
        settle();
        // Smaller pool size keeps the free pool until a release clamps it
        cfg_write(1, 1);
        send_job(CMD_ARRIVE,   CLASS_LOW,  8'h20, 9'd2);
        send_job(CMD_COMPLETE, CLASS_HIGH, 8'h21, 9'd0);
        send_job(CMD_ARRIVE,   CLASS_HIGH, 8'h22, 9'd2);
        send_job(CMD_ARRIVE,   CLASS_HIGH, 8'h23, 9'd0);
        send_job(CMD_COMPLETE, CLASS_LOW,  8'h24, 9'd256);
        settle();
        // Oversized head released by a larger pool; then a full queue drops
        cfg_write(256, 3);
        send_job(CMD_COMPLETE, CLASS_HIGH, 8'h25, 9'd1);
        send_job(CMD_ARRIVE,   CLASS_LOW,  8'h26, 9'd3);
        send_job(CMD_ARRIVE,   CLASS_LOW,  8'h27, 9'd1);
        send_job(CMD_ARRIVE,   CLASS_HIGH, 8'h28, 9'd0);
        send_job(CMD_ARRIVE,   CLASS_LOW,  8'h29, 9'd4);
        send_job(CMD_ARRIVE,   CLASS_HIGH, 8'h2A, 9'd7);
        send_job(CMD_COMPLETE, CLASS_LOW,  8'h2B, 9'd256);
        settle();
        flush_queue();

        // Random phases, each under its own register setting
        for (int p = 0; p < 6; p++) begin
            cfg_write(totals[p], limits[p]);
            quiet = (p == 2);
            for (int n = 0; n < 50; n++) begin
                if (p == 3 && n == 8) hold_req = 1'b1;
                send_random();
            end
            settle();
            flush_queue();
        end
        quiet = 1'b0;

        settle();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Run limit
    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
